[src/bht_pkg.sv]
// Shared types, codes and defaults for the bucketed hash table.
`default_nettype none
package bht_pkg;

  localparam int unsigned BUCKETS_DEF = 40;
  localparam int unsigned SLOTS_DEF   = 3;

  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_DELETED   = 3'd5,
    ST_INVALID   = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [63:0] payload;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  bucket;
    logic [1:0]  slot;
    logic [63:0] record_out;
  } out_item_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_RESOLVE
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic load_in;
    logic read_row;
    logic resolve;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

[src/bht_ctrl.sv]
// Controller state machine: key store clearing, request sequencing.
`default_nettype none
module bht_ctrl
  import bht_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t dp_sts,
  output ctrl_cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (dp_sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (dp_sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_READ: begin
        cmd.read_row = 1'b1;
      end
      S_RESOLVE: begin
        cmd.resolve = dp_sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/bht_datapath.sv]
// Datapath: key canonicalisation, cube-sum hash, bucket store and result register.
`default_nettype none
module bht_datapath
  import bht_pkg::*;
#(
  parameter int unsigned BUCKETS = BUCKETS_DEF,
  parameter int unsigned SLOTS   = SLOTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire ctrl_cmd_t cmd,
  output dp_status_t     dp_sts,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int unsigned BW   = $clog2(BUCKETS);
  localparam int unsigned SUMW = BW + 2;
  localparam logic [SUMW-1:0] B1 = SUMW'(BUCKETS);
  localparam logic [SUMW-1:0] B2 = SUMW'(2 * BUCKETS);

  // cube of each byte code, reduced modulo the bucket count
  logic [BW-1:0] cube_mod [256];
  for (genvar g = 0; g < 256; g++) begin : g_cube
    localparam int unsigned CM = (g * g * g) % BUCKETS;
    assign cube_mod[g] = CM[BW-1:0];
  end

  logic [SLOTS-1:0][31:0] key_mem [BUCKETS];
  logic [SLOTS-1:0][63:0] pay_mem [BUCKETS];

  logic [BW-1:0]          clr_cnt_r;
  logic [1:0]             op_r;
  logic [31:0]            key_r;
  logic [63:0]            payload_r;
  logic [SUMW-1:0]        sum_r;
  logic [BW-1:0]          bucket_r;
  logic [SLOTS-1:0][31:0] key_rd_r;
  logic [SLOTS-1:0][63:0] pay_rd_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic [31:0]            canon;
  logic [SUMW-1:0]        sum_nxt;
  logic [SUMW-1:0]        red1;
  logic [SUMW-1:0]        red2;
  logic [BW-1:0]          bucket_nxt;

  // key is cut at its first zero byte
  always_comb begin
    logic live;
    live  = 1'b1;
    canon = '0;
    for (int i = 0; i < 4; i++) begin
      if (in_data.key[8*i +: 8] == 8'd0) live = 1'b0;
      if (live) canon[8*i +: 8] = in_data.key[8*i +: 8];
    end
    sum_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      sum_nxt = sum_nxt + SUMW'(cube_mod[canon[8*i +: 8]]);
    end
  end

  // sum of four residues is below four times the bucket count
  always_comb begin
    red1       = (sum_r >= B2) ? sum_r - B2 : sum_r;
    red2       = (red1 >= B1) ? red1 - B1 : red1;
    bucket_nxt = red2[BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r      <= in_data.op;
      key_r     <= canon;
      payload_r <= in_data.payload;
      sum_r     <= sum_nxt;
    end
    if (cmd.read_row) begin
      bucket_r <= bucket_nxt;
      key_rd_r <= key_mem[bucket_nxt];
      pay_rd_r <= pay_mem[bucket_nxt];
    end
  end

  // first matching and first empty slot, one-hot
  logic [SLOTS-1:0] match_oh, empty_oh;
  logic             any_match, any_empty;
  logic [2:0]       match_idx, empty_idx;
  logic [63:0]      match_rec;

  always_comb begin
    match_oh  = '0;
    empty_oh  = '0;
    any_match = 1'b0;
    any_empty = 1'b0;
    match_idx = '0;
    empty_idx = '0;
    match_rec = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!any_match && key_rd_r[s] == key_r) begin
        any_match   = 1'b1;
        match_oh[s] = 1'b1;
        match_idx   = 3'(s);
        match_rec   = pay_rd_r[s];
      end
      if (!any_empty && key_rd_r[s] == 32'd0) begin
        any_empty   = 1'b1;
        empty_oh[s] = 1'b1;
        empty_idx   = 3'(s);
      end
    end
  end

  out_item_t              res;
  logic                   key_we, pay_we;
  logic [BW-1:0]          key_wa;
  logic [SLOTS-1:0][31:0] key_wd;
  logic [SLOTS-1:0][63:0] pay_wd;

  always_comb begin
    res            = '0;
    res.status     = ST_NOT_FOUND;
    key_we         = 1'b0;
    pay_we         = 1'b0;
    key_wa         = bucket_r;
    key_wd         = key_rd_r;
    pay_wd         = pay_rd_r;
    if (key_r == 32'd0) begin
      res.status = ST_INVALID;
    end else begin
      res.bucket = 6'(bucket_r);
      priority if (op_r == OP_INSERT) begin
        priority if (any_match) begin
          res.status     = ST_DUPLICATE;
          res.slot       = match_idx[1:0];
          res.record_out = match_rec;
        end else if (any_empty) begin
          res.status = ST_INSERTED;
          res.slot   = empty_idx[1:0];
          key_we     = cmd.resolve;
          pay_we     = cmd.resolve;
          for (int s = 0; s < SLOTS; s++) begin
            if (empty_oh[s]) begin
              key_wd[s] = key_r;
              pay_wd[s] = payload_r;
            end
          end
        end else begin
          res.status = ST_OVERFLOW;
        end
      end else if (op_r == OP_DELETE) begin
        if (any_match) begin
          res.status     = ST_DELETED;
          res.slot       = match_idx[1:0];
          res.record_out = match_rec;
          key_we         = cmd.resolve;
          for (int s = 0; s < SLOTS; s++) begin
            if (match_oh[s]) key_wd[s] = 32'd0;
          end
        end
      end else begin
        if (any_match) begin
          res.status     = ST_FOUND;
          res.slot       = match_idx[1:0];
          res.record_out = match_rec;
        end
      end
    end
    if (cmd.clear_wr) begin
      key_we = 1'b1;
      key_wa = clr_cnt_r;
      key_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    if (pay_we) pay_mem[bucket_r] <= pay_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resolve) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) out_r <= res;
  end

  assign dp_sts.clear_last = (clr_cnt_r == BW'(BUCKETS - 1));
  assign dp_sts.out_free   = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_data          = out_r;

endmodule
`default_nettype wire

[src/bucketed_hash_table.sv]
// Each request runs through the hash, bucket row read and compare/write-back steps in order;
// a new request is taken only once the request before it has finished its write-back step.
// A request is taken while the previous result still waits in the output register.
// A pending result stalls only the write-back step until it is transferred.
// After reset the key store is cleared one bucket row a cycle, in_ready low, until every row is clear.
// Reset is synchronous, active low.
`default_nettype none
module bucketed_hash_table
  import bht_pkg::*;
#(
  parameter int unsigned BUCKETS = BUCKETS_DEF,
  parameter int unsigned SLOTS   = SLOTS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_sts;

  bht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .dp_sts   (dp_sts),
    .cmd      (cmd)
  );

  bht_datapath #(
    .BUCKETS (BUCKETS),
    .SLOTS   (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .dp_sts    (dp_sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input transfer taken while a request is in flight");

  a_no_transfer_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_wr |-> !in_ready)
    else $error("input ready during key store clear");

  a_result_from_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.resolve))
    else $error("result raised without a write-back step");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_wr, cmd.load_in, cmd.read_row, cmd.resolve}))
    else $error("more than one datapath command at once");
`endif

endmodule
`default_nettype wire
